// File: src/cpba_pkg.sv
// Shared constants and types for the contiguous page bitmap allocator.
`timescale 1ns / 1ps

package cpba_pkg;

  localparam int WORD_BITS  = 32;
  localparam int POS_W      = 5;
  localparam int CNT_W      = 6;
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } match_t;

endpackage

// File: src/cpba_if.sv
// Request and response channel interfaces of the page allocator.
`timescale 1ns / 1ps

interface cpba_req_if import cpba_pkg::*;;
  logic              valid;
  logic              ready;
  logic              action;
  logic [CNT_W-1:0]  page_count;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, action, page_count, free_address, input ready);
  modport sink   (input valid, action, page_count, free_address, output ready);
endinterface

interface cpba_rsp_if import cpba_pkg::*;;
  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] run_address;
  logic [CNT_W-1:0]  freed_count;

  modport source (output valid, found, run_address, freed_count, input ready);
  modport sink   (input valid, found, run_address, freed_count, output ready);
endinterface

// File: src/contiguous_page_bitmap_allocator.sv
// Top level: first-fit contiguous page allocator over a used-page bitmap.
// Allocate scans one bitmap word per cycle; a bad length goes straight to ST_DONE.
// Free reads two words, then writes both back. One request is in flight at a time.
// The response register lets a new request enter while a result waits.
// After reset a clearing pass writes WORD_COUNT words before in_ch.ready rises.
`timescale 1ns / 1ps

module contiguous_page_bitmap_allocator import cpba_pkg::*; #(
  parameter int POOL_PAGES = 1024,
  parameter int MAX_RUN    = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  cpba_req_if.sink          in_ch,
  cpba_rsp_if.source        out_ch
);

  localparam int WORD_COUNT = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int TW         = $clog2(WORD_COUNT + 1);
  localparam int PW         = TW + POS_W;
  localparam int REM        = POOL_PAGES % WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    (REM == 0) ? {WORD_BITS{1'b1}} : WORD_BITS'((64'd1 << REM) - 64'd1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_A_WR0, ST_A_WR1,
    ST_F_RD1, ST_F_RD2, ST_F_WR0, ST_F_WR1, ST_DONE
  } state_t;

  state_t                 state_r;
  logic [AW-1:0]          clr_idx_r;
  logic [ADDR_W-1:0]      base_r;
  logic [WORD_BITS-1:0]   win_r;
  logic [TW-1:0]          t_r;
  logic [WORD_BITS-1:0]   prev_used_r;
  logic [WORD_BITS-1:0]   prev_free_r;
  logic [WORD_BITS-1:0]   cur_used_r;
  logic                   wr_cur_r;
  logic [PW-1:0]          page_r;
  logic                   found_r;
  logic [CNT_W-1:0]       freed_r;
  logic [14:0]            ws_r;
  logic [POS_W-1:0]       off_r;
  logic [WORD_BITS-1:0]   lo_r;
  logic [WORD_BITS-1:0]   hi_r;
  logic [WORD_BITS-1:0]   lo_mask_r;
  logic [WORD_BITS-1:0]   hi_mask_r;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [ADDR_W-1:0]      out_addr_r;
  logic [CNT_W-1:0]       out_freed_r;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;

  logic                   in_fire;
  logic                   out_load;
  logic                   len_ok;
  logic [ADDR_W-1:0]      offs;
  logic                   cur_in;
  logic [WORD_BITS-1:0]   cur_free;
  logic [2*WORD_BITS-1:0] mark;
  logic [2*WORD_BITS-1:0] fmask;
  match_t                 match;

  function automatic logic [WORD_BITS-1:0] word_mask(input logic [16:0] w);
    logic [WORD_BITS-1:0] m;
    if (w < 17'(WORD_COUNT - 1)) begin
      m = {WORD_BITS{1'b1}};
    end else if (w == 17'(WORD_COUNT - 1)) begin
      m = LAST_MASK;
    end else begin
      m = '0;
    end
    return m;
  endfunction

  function automatic logic [CNT_W-1:0] popcnt(input logic [WORD_BITS-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c + CNT_W'(v[i]);
    end
    return c;
  endfunction

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_load           = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign len_ok             = (in_ch.page_count != '0) &&
                              (in_ch.page_count <= CNT_W'(MAX_RUN));
  assign offs               = in_ch.free_address - base_r;
  assign cur_in             = (t_r < TW'(WORD_COUNT));
  assign cur_free           = cur_in ? (~ram_rdata & word_mask(17'(t_r))) : '0;
  assign mark               = {{WORD_BITS{1'b0}}, win_r} << match.pos;
  assign fmask              = {{WORD_BITS{1'b0}}, win_r} << off_r;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.run_address = out_addr_r;
  assign out_ch.freed_count = out_freed_r;

  cpba_run_match u_match (
    .win_mask  (win_r),
    .free_pair ({cur_free, prev_free_r}),
    .result    (match)
  );

  cpba_bitmap_ram #(
    .DEPTH (WORD_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
      end
      ST_IDLE: begin
        if (in_ch.action == ACT_FREE) begin
          ram_raddr = offs[AW+16:17];
        end
      end
      ST_SCAN: begin
        ram_raddr = AW'(t_r + 1'b1);
      end
      ST_A_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(t_r - 1'b1);
        ram_wdata = prev_used_r;
      end
      ST_A_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(t_r);
        ram_wdata = cur_used_r;
      end
      ST_F_RD1: begin
        ram_raddr = AW'(ws_r + 1'b1);
      end
      ST_F_WR0: begin
        ram_we    = (lo_mask_r != '0);
        ram_waddr = ws_r[AW-1:0];
        ram_wdata = lo_r & ~lo_mask_r;
      end
      ST_F_WR1: begin
        ram_we    = (hi_mask_r != '0);
        ram_waddr = AW'(ws_r + 1'b1);
        ram_wdata = hi_r & ~hi_mask_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == AW'(WORD_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            win_r       <= WORD_BITS'((33'd1 << in_ch.page_count[POS_W:0]) - 33'd1);
            found_r     <= 1'b0;
            freed_r     <= '0;
            t_r         <= '0;
            prev_free_r <= '0;
            ws_r        <= offs[31:17];
            off_r       <= offs[16:12];
            if (!len_ok) begin
              state_r <= ST_DONE;
            end else if (in_ch.action == ACT_ALLOC) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_F_RD1;
            end
          end
        end
        ST_SCAN: begin
          if (match.hit) begin
            prev_used_r <= prev_used_r | mark[WORD_BITS-1:0];
            cur_used_r  <= ram_rdata | mark[2*WORD_BITS-1:WORD_BITS];
            wr_cur_r    <= cur_in;
            page_r      <= {TW'(t_r - 1'b1), match.pos};
            found_r     <= 1'b1;
            state_r     <= ST_A_WR0;
          end else if (!cur_in) begin
            state_r <= ST_DONE;
          end else begin
            prev_used_r <= ram_rdata;
            prev_free_r <= cur_free;
            t_r         <= t_r + 1'b1;
          end
        end
        ST_A_WR0: begin
          state_r <= wr_cur_r ? ST_A_WR1 : ST_DONE;
        end
        ST_A_WR1: begin
          state_r <= ST_DONE;
        end
        ST_F_RD1: begin
          lo_r      <= ram_rdata;
          lo_mask_r <= fmask[WORD_BITS-1:0] & word_mask({2'b00, ws_r});
          hi_mask_r <= fmask[2*WORD_BITS-1:WORD_BITS] &
                       word_mask({2'b00, ws_r} + 17'd1);
          state_r   <= ST_F_RD2;
        end
        ST_F_RD2: begin
          hi_r    <= ram_rdata;
          state_r <= ST_F_WR0;
        end
        ST_F_WR0: begin
          freed_r <= popcnt(lo_r & lo_mask_r) + popcnt(hi_r & hi_mask_r);
          state_r <= ST_F_WR1;
        end
        ST_F_WR1: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_found_r <= found_r;
            out_freed_r <= freed_r;
            out_addr_r  <= found_r ?
                           base_r + ADDR_W'({page_r, {PAGE_SHIFT{1'b0}}}) : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ch.ready)
    else $error("request accepted during clearing pass");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !ram_we)
    else $error("bitmap write during search");

  a_found_no_freed: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found |-> out_ch.freed_count == '0)
    else $error("allocate response carries a freed count");

  a_miss_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.run_address == '0)
    else $error("non-allocating response carries an address");

endmodule

// File: src/cpba_bitmap_ram.sv
// Single-port-write, single-port-read bitmap memory with registered read data.
`timescale 1ns / 1ps

module cpba_bitmap_ram import cpba_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/cpba_run_match.sv
// First-fit window match over a pair of bitmap words.
`timescale 1ns / 1ps

module cpba_run_match import cpba_pkg::*; (
  input  logic [WORD_BITS-1:0]   win_mask,
  input  logic [2*WORD_BITS-1:0] free_pair,
  output match_t                 result
);

  logic [WORD_BITS-1:0] ok;

  always_comb begin
    for (int s = 0; s < WORD_BITS; s++) begin
      ok[s] = &(free_pair[s +: WORD_BITS] | ~win_mask);
    end
  end

  // lowest start position wins
  always_comb begin
    result.hit = |ok;
    result.pos = '0;
    for (int s = WORD_BITS - 1; s >= 0; s--) begin
      if (ok[s]) begin
        result.pos = POS_W'(s);
      end
    end
  end

endmodule
